// File: src/trapezoid_segment_time_allocator_defines.svh
// Assertion macros shared by the checker files.
// Needs signals clk and rst_n in the scope where a macro is used.
`ifndef TRAPEZOID_SEGMENT_TIME_ALLOCATOR_DEFINES_SVH
`define TRAPEZOID_SEGMENT_TIME_ALLOCATOR_DEFINES_SVH

// Consequent in the cycle after the antecedent, ignored while in reset.
`define TSTA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsta assertion failed");

// Same cycle implication, ignored while in reset.
`define TSTA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsta assertion failed");

// Next-cycle implication that is also checked through reset.
`define TSTA_ASSERT_RESET(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tsta assertion failed");

`endif

// File: src/tsta_pkg.sv
// Shared types and constants for the trapezoid segment time allocator.
// No dependencies.
package tsta_pkg;

  localparam int PosW   = 24;
  localparam int DiffW  = 25;
  localparam int CntW   = 16;
  localparam int LimW   = 16;
  localparam int DurW   = 32;
  localparam int RadW   = 56;  // square root radicand
  localparam int RootW  = 28;
  localparam int DvdW   = 54;  // divider dividend / quotient
  localparam int DvsW   = 32;
  localparam int LenW   = 25;

  typedef enum logic {
    REG_MAX_VELOCITY     = 1'b0,
    REG_MAX_ACCELERATION = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic signed [DiffW-1:0] dz;
    logic [CntW-1:0]         seg_num;
  } seg_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQ,
    B_LEN_WAIT,
    B_MUL,
    B_DECIDE,
    B_DIV_WAIT,
    B_TRI_WAIT,
    B_EMIT
  } back_state_t;

endpackage

// File: src/tsta_front.sv
// Front end: accepts waypoints, tracks route state, forms segment deltas.
// Depends on tsta_pkg.
module tsta_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [71:0]                 in_tdata,   // pos_x, pos_y, pos_z
  input  logic [0:0]                  in_tuser,   // route_start
  input  tsta_pkg::q_status_t         q_status,
  output logic                        push,
  output tsta_pkg::seg_item_t         push_item
);

  logic [tsta_pkg::PosW-1:0] prev_x_r, prev_y_r, prev_z_r;
  logic                      have_prev_r;
  logic [tsta_pkg::CntW-1:0] cnt_r;
  logic [tsta_pkg::PosW-1:0] x, y, z;
  logic                      accept, new_route;

  assign x = in_tdata[23:0];
  assign y = in_tdata[47:24];
  assign z = in_tdata[71:48];

  assign in_tready = !q_status.full;
  assign accept    = in_tvalid && in_tready;
  assign new_route = in_tuser[0] || !have_prev_r;
  assign push      = accept && !new_route;

  always_comb begin
    push_item.dx      = $signed({x[23], x}) - $signed({prev_x_r[23], prev_x_r});
    push_item.dy      = $signed({y[23], y}) - $signed({prev_y_r[23], prev_y_r});
    push_item.dz      = $signed({z[23], z}) - $signed({prev_z_r[23], prev_z_r});
    push_item.seg_num = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_z_r    <= '0;
      have_prev_r <= 1'b0;
      cnt_r       <= '0;
    end else if (accept) begin
      prev_x_r    <= x;
      prev_y_r    <= y;
      prev_z_r    <= z;
      have_prev_r <= 1'b1;
      cnt_r       <= new_route ? '0 : cnt_r + 1'b1;
    end
  end

endmodule

// File: src/tsta_queue.sv
// Two-entry queue of segment items between front and back end.
// Depends on tsta_pkg.
module tsta_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tsta_pkg::seg_item_t push_item,
  input  logic                pop,
  output tsta_pkg::seg_item_t pop_item,
  output tsta_pkg::q_status_t status
);

  tsta_pkg::seg_item_t mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);
  assign pop_item     = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: src/tsta_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on tsta_pkg.
module tsta_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tsta_pkg::RadW-1:0]     radicand,
  output logic                          done,
  output logic [tsta_pkg::RootW-1:0]    root
);

  logic [tsta_pkg::RadW-1:0]  rad_r;
  logic [29:0]                rem_r;
  logic [tsta_pkg::RootW-1:0] root_r;
  logic [4:0]                 step_r;
  logic                       busy_r, done_r;
  logic [30:0]                rem_sh, trial, rem_sub;
  logic                       fits;

  assign rem_sh  = {rem_r[28:0], rad_r[55:54]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign fits    = (rem_sh >= trial);
  assign rem_sub = rem_sh - trial;
  assign done    = done_r;
  assign root    = root_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[53:0], 2'b00};
      rem_r  <= fits ? rem_sub[29:0] : rem_sh[29:0];
      root_r <= {root_r[26:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == 5'(tsta_pkg::RootW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: src/tsta_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on tsta_pkg.
module tsta_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tsta_pkg::DvdW-1:0]   dividend,
  input  logic [tsta_pkg::DvsW-1:0]   divisor,
  output logic                        done,
  output logic [tsta_pkg::DvdW-1:0]   quotient
);

  logic [tsta_pkg::DvdW-1:0] quo_r;
  logic [tsta_pkg::DvsW-1:0] dvs_r, rem_r;
  logic [5:0]                step_r;
  logic                      busy_r, done_r;
  logic [tsta_pkg::DvsW:0]   rem_sh, rem_sub;
  logic                      fits;

  assign rem_sh   = {rem_r, quo_r[tsta_pkg::DvdW-1]};
  assign fits     = (rem_sh >= {1'b0, dvs_r});
  assign rem_sub  = rem_sh - {1'b0, dvs_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[tsta_pkg::DvdW-2:0], fits};
      rem_r <= fits ? rem_sub[tsta_pkg::DvsW-1:0] : rem_sh[tsta_pkg::DvsW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == 6'(tsta_pkg::DvdW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: src/tsta_back.sv
// Back end: segment length, profile choice and travel time, output register.
// Depends on tsta_pkg, tsta_isqrt, tsta_divider.
module tsta_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [tsta_pkg::LimW-1:0]    max_velocity,
  input  logic [tsta_pkg::LimW-1:0]    max_acceleration,
  input  tsta_pkg::q_status_t          q_status,
  input  tsta_pkg::seg_item_t          pop_item,
  output logic                         pop,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [47:0]                  out_tdata,
  output logic [0:0]                   out_tuser
);

  tsta_pkg::back_state_t state_r, state_nxt;

  logic [tsta_pkg::DiffW-1:0] mag_r [3];
  logic [1:0]                 idx_r;
  logic [49:0]                acc_r, prod, acc_sum;
  logic [tsta_pkg::CntW-1:0]  seg_r;
  logic [tsta_pkg::LenW-1:0]  len_r;
  logic [40:0]                ra_r;
  logic [31:0]                vv_r, va_r;
  logic                       tri_r;
  logic [tsta_pkg::DurW-1:0]  dur_r;
  logic [tsta_pkg::LimW-1:0]  v, a;
  logic [tsta_pkg::DiffW-1:0] dmag [3];

  logic                        sq_start, sq_done;
  logic [tsta_pkg::RadW-1:0]   sq_rad;
  logic [tsta_pkg::RootW-1:0]  sq_root;
  logic                        dv_start, dv_done;
  logic [tsta_pkg::DvdW-1:0]   dv_dvd, dv_quo;
  logic [tsta_pkg::DvsW-1:0]   dv_dvs;
  logic                        tri_now, load_out;

  logic                        out_valid_r;
  logic [tsta_pkg::DurW-1:0]   out_dur_r;
  logic [tsta_pkg::CntW-1:0]   out_seg_r;
  logic                        out_tri_r;

  // a zero limit is treated as one
  assign v = (max_velocity == '0) ? 16'd1 : max_velocity;
  assign a = (max_acceleration == '0) ? 16'd1 : max_acceleration;

  assign dmag[0] = pop_item.dx[24] ? 25'(-pop_item.dx) : pop_item.dx;
  assign dmag[1] = pop_item.dy[24] ? 25'(-pop_item.dy) : pop_item.dy;
  assign dmag[2] = pop_item.dz[24] ? 25'(-pop_item.dz) : pop_item.dz;

  assign prod    = 50'(mag_r[idx_r]) * 50'(mag_r[idx_r]);
  assign acc_sum = acc_r + prod;
  assign tri_now = (ra_r < {5'b0, vv_r, 4'b0});

  tsta_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_rad),
    .done     (sq_done),
    .root     (sq_root)
  );

  tsta_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (dv_dvd),
    .divisor  (dv_dvs),
    .done     (dv_done),
    .quotient (dv_quo)
  );

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    sq_start  = 1'b0;
    sq_rad    = {6'b0, acc_sum};
    dv_start  = 1'b0;
    dv_dvd    = {len_r, 29'b0} >> 1;
    dv_dvs    = {16'b0, a};
    load_out  = 1'b0;
    unique case (state_r)
      tsta_pkg::B_IDLE: begin
        if (!q_status.empty) begin
          pop       = 1'b1;
          state_nxt = tsta_pkg::B_SQ;
        end
      end
      tsta_pkg::B_SQ: begin
        if (idx_r == 2'd2) begin
          sq_start  = 1'b1;
          state_nxt = tsta_pkg::B_LEN_WAIT;
        end
      end
      tsta_pkg::B_LEN_WAIT: begin
        if (sq_done) state_nxt = tsta_pkg::B_MUL;
      end
      tsta_pkg::B_MUL: begin
        state_nxt = tsta_pkg::B_DECIDE;
      end
      tsta_pkg::B_DECIDE: begin
        dv_start = 1'b1;
        if (tri_now) begin
          dv_dvd = {1'b0, len_r, 28'b0};
          dv_dvs = {16'b0, a};
        end else begin
          dv_dvd = {1'b0, ra_r, 12'b0} + {6'b0, vv_r, 16'b0};
          dv_dvs = va_r;
        end
        state_nxt = tsta_pkg::B_DIV_WAIT;
      end
      tsta_pkg::B_DIV_WAIT: begin
        if (dv_done) begin
          if (tri_r) begin
            sq_start  = 1'b1;
            sq_rad    = {dv_quo, 2'b00};
            state_nxt = tsta_pkg::B_TRI_WAIT;
          end else begin
            state_nxt = tsta_pkg::B_EMIT;
          end
        end
      end
      tsta_pkg::B_TRI_WAIT: begin
        if (sq_done) state_nxt = tsta_pkg::B_EMIT;
      end
      tsta_pkg::B_EMIT: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = tsta_pkg::B_IDLE;
        end
      end
      default: state_nxt = tsta_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsta_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      mag_r[0] <= dmag[0];
      mag_r[1] <= dmag[1];
      mag_r[2] <= dmag[2];
      seg_r    <= pop_item.seg_num;
      acc_r    <= '0;
      idx_r    <= '0;
    end else if (state_r == tsta_pkg::B_SQ) begin
      acc_r <= acc_sum;
      idx_r <= idx_r + 1'b1;
    end
    if (state_r == tsta_pkg::B_LEN_WAIT && sq_done) begin
      len_r <= sq_root[tsta_pkg::LenW-1:0];
    end
    if (state_r == tsta_pkg::B_MUL) begin
      ra_r <= 41'(len_r) * 41'(a);
      vv_r <= 32'(v) * 32'(v);
      va_r <= 32'(v) * 32'(a);
    end
    if (state_r == tsta_pkg::B_DECIDE) begin
      tri_r <= tri_now;
    end
    if (state_r == tsta_pkg::B_DIV_WAIT && dv_done) begin
      dur_r <= (dv_quo[tsta_pkg::DvdW-1:32] != '0) ? '1 : dv_quo[31:0];
    end
    if (state_r == tsta_pkg::B_TRI_WAIT && sq_done) begin
      dur_r <= {4'b0, sq_root};
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_dur_r <= dur_r;
      out_seg_r <= seg_r;
      out_tri_r <= tri_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_seg_r, out_dur_r};
  assign out_tuser  = out_tri_r;

endmodule

// File: src/trapezoid_segment_time_allocator.sv
// Channel   | dir | tdata                              | tuser
// in_       | in  | pos_x[23:0] pos_y[47:24] pos_z[71:48] | route_start
// out_      | out | segment_duration[31:0] segment_number[47:32] | triangular_profile
// cfg_      | in  | index 0 max_velocity, 1 max_acceleration, write only
// The back end handles one segment at a time, using the 28-step root unit and the 54-step
// divider; a triangular segment passes through the root unit a second time.
// Route starts leave no work for the back end.
// A two-entry queue lets the front accept waypoints while the back end computes.
// Reset is synchronous, active low; results hold while out_tready is low.
// Top level of the trapezoid segment time allocator.
// Depends on tsta_pkg, tsta_front, tsta_queue, tsta_back.
module trapezoid_segment_time_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // pos_x, pos_y, pos_z
  input  logic [0:0]  in_tuser,   // route_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // segment_duration, segment_number
  output logic [0:0]  out_tuser,  // triangular_profile
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  logic [tsta_pkg::LimW-1:0] max_vel_r, max_acc_r;
  tsta_pkg::q_status_t       q_status;
  tsta_pkg::seg_item_t       push_item, pop_item;
  logic                      push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_vel_r <= 16'd256;
      max_acc_r <= 16'd256;
    end else if (cfg_we) begin
      unique case (tsta_pkg::cfg_reg_t'(cfg_addr))
        tsta_pkg::REG_MAX_VELOCITY:     max_vel_r <= cfg_wdata;
        tsta_pkg::REG_MAX_ACCELERATION: max_acc_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tsta_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  tsta_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  tsta_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .max_velocity     (max_vel_r),
    .max_acceleration (max_acc_r),
    .q_status         (q_status),
    .pop_item         (pop_item),
    .pop              (pop),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser)
  );

endmodule

// File: src/tsta_checker.sv
// Port-level checks for the trapezoid segment time allocator, bound to the top.
// Depends on trapezoid_segment_time_allocator_defines.svh.
`include "trapezoid_segment_time_allocator_defines.svh"

module tsta_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // stalled result beat holds
  `TSTA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // reset empties the output register
  `TSTA_ASSERT_RESET(a_reset_clear, !rst_n, !out_tvalid)

  // a trapezoidal segment always takes nonzero time (at least 2V/A)
  `TSTA_ASSERT_SAME(a_trap_nonzero, out_tvalid && !out_tuser[0], out_tdata[31:0] != 32'd0)

endmodule

bind trapezoid_segment_time_allocator tsta_checker u_tsta_checker (.*);

// File: verif/trapezoid_segment_time_allocator_tb.sv
// Self-checking bench for trapezoid_segment_time_allocator: waypoint beats in, segment times out.
// Directed table then random routes under several idle/stall mixes; checks every result beat.
// Depends on tsta_pkg and the RTL of the block.
module trapezoid_segment_time_allocator_tb;

  localparam int CycleLimit = 2000000;
  localparam int SettleCycles = 160;  // longest back-end pass plus margin

  localparam tsta_pkg::cfg_reg_t RegVel = tsta_pkg::REG_MAX_VELOCITY;
  localparam tsta_pkg::cfg_reg_t RegAcc = tsta_pkg::REG_MAX_ACCELERATION;

  typedef struct {
    logic [31:0] dur;
    logic [15:0] num;
    logic        tri_prof;
  } seg_time_t;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    tsta_pkg::cfg_reg_t  idx;
    logic [15:0]         val;
    logic [23:0]         x, y, z;
    logic                st;
    logic                typed;
    logic [31:0]         dur;
    logic [15:0]         num;
    logic                tri_prof;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;   // pos_x, pos_y, pos_z
  logic [0:0]  in_tuser = '0;   // route_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // segment_duration, segment_number
  logic [0:0]  out_tuser;       // triangular_profile
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  trapezoid_segment_time_allocator u_top (.*);

  // predictor state
  logic [15:0] vel_lim = 16'd256, acc_lim = 16'd256;
  logic [23:0] last_x = '0, last_y = '0, last_z = '0;
  logic        have_last = 1'b0;
  logic [15:0] seg_cnt = '0;

  seg_time_t   expected_segs[$];
  int          errors = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off = 0;

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls, plus an optional long hold-off counted down here
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    seg_time_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_segs.size() == 0) begin
        report("unexpected result beat, duration", out_tdata[31:0], 0);
      end else begin
        want = expected_segs.pop_front();
        if (out_tdata[31:0] !== want.dur) report("segment_duration", out_tdata[31:0], want.dur);
        if (out_tdata[47:32] !== want.num) report("segment_number", out_tdata[47:32], want.num);
        if (out_tuser[0] !== want.tri_prof) report("triangular_profile", out_tuser[0], want.tri_prof);
      end
    end
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] rem, root, b;
    rem = n;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] sq_delta(logic [23:0] p, logic [23:0] q);
    longint d;
    d = longint'($signed(p)) - longint'($signed(q));
    if (d < 0) d = -d;
    return d * d;
  endfunction

  // Returns 1 when the waypoint closes a segment; updates the tracked route state.
  function automatic bit segment_time(logic [23:0] x, y, z, logic st, output seg_time_t res);
    logic [63:0] v, a, len, q, dur;
    bit made;
    made = 0;
    if (st || !have_last) begin
      have_last = 1'b1;
      seg_cnt = '0;
    end else begin
      v = (vel_lim == 0) ? 64'd1 : 64'(vel_lim);  // zero limit behaves as one
      a = (acc_lim == 0) ? 64'd1 : 64'(acc_lim);
      len = int_sqrt(sq_delta(x, last_x) + sq_delta(y, last_y) + sq_delta(z, last_z));
      res.tri_prof = (len * a) < (16 * v * v);
      if (res.tri_prof) begin
        q = (len << 28) / a;
        dur = int_sqrt(q << 2);
      end else begin
        dur = ((len << 12) * a + ((v * v) << 16)) / (v * a);
      end
      res.dur = (dur > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dur[31:0];
      res.num = seg_cnt;
      seg_cnt++;
      made = 1;
    end
    last_x = x;
    last_y = y;
    last_z = z;
    return made;
  endfunction

  task automatic send_waypoint(logic [23:0] x, y, z, logic st, logic typed = 0,
                               seg_time_t typed_res = '{0, 0, 0});
    seg_time_t res;
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {z, y, x};
    in_tuser <= st;
    do @(posedge clk); while (!in_tready);
    if (segment_time(x, y, z, st, res)) expected_segs.push_back(typed ? typed_res : res);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_segs.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(tsta_pkg::cfg_reg_t idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == RegVel) vel_lim = val;
    else acc_lim = val;
  endtask

  function automatic logic [23:0] rand_step(logic [23:0] p);
    logic [23:0] mag;
    mag = 24'($urandom) & ((24'd1 << $urandom_range(0, 23)) - 24'd1);
    return ($urandom_range(1) != 0) ? p + mag : p - mag;
  endfunction

  localparam logic [23:0] PMin = 24'h800000, PMax = 24'h7FFFFF;

  stim_row_t dir_rows[] = '{
    // first beat after reset opens a route even without the start flag
    '{ROW_BEAT, RegVel, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_BEAT, RegVel, 0, 0, 0, 0, 0, 1, 32'd0, 16'd0, 1},  // coincident
    '{ROW_BEAT, RegVel, 0, 4096, 0, 0, 0, 1, 32'd131072, 16'd1, 0},
    '{ROW_BEAT, RegVel, 0, 4112, 0, 0, 0, 1, 32'd8192, 16'd2, 1},
    '{ROW_BEAT, RegVel, 0, PMin, PMin, PMin, 1, 0, 0, 0, 0},
    '{ROW_BEAT, RegVel, 0, PMax, PMin, PMin, 0, 1, 32'd268500976, 16'd0, 0},
    '{ROW_BEAT, RegVel, 0, PMax, PMax, PMax, 0, 0, 0, 0, 0},
    '{ROW_BEAT, RegVel, 0, PMin, PMin, PMin, 0, 0, 0, 0, 0},
    '{ROW_CFG, RegVel, 16'd1, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG, RegAcc, 16'd1, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_BEAT, RegVel, 0, PMin, 0, 0, 1, 0, 0, 0, 0},
    '{ROW_BEAT, RegVel, 0, PMax, 0, 0, 0, 1, 32'hFFFF_FFFF, 16'd0, 0},  // saturates
    '{ROW_BEAT, RegVel, 0, PMax, 0, 5, 0, 0, 0, 0, 0},
    '{ROW_CFG, RegVel, 16'd0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG, RegAcc, 16'd0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_BEAT, RegVel, 0, PMax, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_BEAT, RegVel, 0, PMin, 0, 0, 0, 1, 32'hFFFF_FFFF, 16'd3, 0},
    '{ROW_CFG, RegVel, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG, RegAcc, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_BEAT, RegVel, 0, PMax, PMax, PMax, 0, 0, 0, 0, 0},
    '{ROW_BEAT, RegVel, 0, 24'h001000, 24'hFFF000, 0, 1, 0, 0, 0, 0},
    '{ROW_BEAT, RegVel, 0, 24'h001234, 24'hFFF100, 24'h000777, 0, 0, 0, 0, 0}
  };

  initial begin
    int pats[4][2] = '{'{0, 0}, '{53, 0}, '{0, 53}, '{17, 17}};
    logic [23:0] px, py, pz;
    int n;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_waypoint(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].st,
                      dir_rows[i].typed,
                      '{dir_rows[i].dur, dir_rows[i].num, dir_rows[i].tri_prof});
      end
    end
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(RegVel, 16'd256); write_reg(RegAcc, 16'd256); end
        3: begin write_reg(RegVel, 16'd1); write_reg(RegAcc, 16'd65535); end
        5: begin write_reg(RegVel, 16'd65535); write_reg(RegAcc, 16'd1); end
        default: begin
          write_reg(RegVel, 16'($urandom_range(1, 65535) >> $urandom_range(0, 15)));
          write_reg(RegAcc, 16'($urandom_range(1, 65535) >> $urandom_range(0, 15)));
        end
      endcase
      send_idle_pct = pats[ph % 4][0];
      recv_stall_pct = pats[ph % 4][1];
      if (ph == 1) hold_off = 1500;  // long hold-off: queue fills, input stalls
      n = 0;
      while (n < 190) begin
        // well-formed routes with random deltas; now and then an isolated random beat
        if ($urandom_range(9) == 0) begin
          send_waypoint(24'($urandom), 24'($urandom), 24'($urandom), 1'($urandom_range(1)));
          n++;
        end else begin
          px = 24'($urandom);
          py = 24'($urandom);
          pz = 24'($urandom);
          send_waypoint(px, py, pz, 1'b1);
          n++;
          repeat ($urandom_range(1, 8)) begin
            px = rand_step(px);
            py = rand_step(py);
            pz = rand_step(pz);
            send_waypoint(px, py, pz, 1'b0);
            n++;
          end
        end
      end
      drain();
    end

    if (errors == 0 && expected_segs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
